// ----- sv/slcl_pkg.sv -----
// Shared types and constants for the set-associative LRU cache lookup block.
// Used by the controller, the datapath and the top level; depends on nothing.
package slcl_pkg;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int SET_BITS_W   = 4;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_W       = 4;
    localparam int TOTAL_W      = 32;
    localparam int OUTCOME_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    localparam logic [SET_BITS_W-1:0]   SET_BITS_RESET   = 4'd1;
    localparam logic [BLOCK_BITS_W-1:0] BLOCK_BITS_RESET = 5'd4;
    localparam logic [WAYS_W-1:0]       WAYS_RESET       = 4'd1;

    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FILL  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_EVICT = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- sv/slcl_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the set rows of the cache; depends on nothing.
module slcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/slcl_ctrl.sv -----
// Controller state machine: clearing pass, input acceptance and update sequencing.
// Depends on slcl_pkg for the command and status structs.
module slcl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output slcl_pkg::dp_cmd_t   cmd,
    input  slcl_pkg::dp_status_t status
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_UPDATE = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.accept     = 1'b0;
        cmd.update     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (status.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/slcl_dp.sv -----
// Datapath: configuration registers, address split, set-row store, way compare,
// LRU rank update, saturating totals and the output register.
// Depends on slcl_pkg and slcl_ram.
module slcl_dp #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [slcl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [slcl_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [63:0]                          address,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [slcl_pkg::OUTCOME_W-1:0]       outcome,
    output logic [slcl_pkg::TOTAL_W-1:0]         hit_total,
    output logic [slcl_pkg::TOTAL_W-1:0]         miss_total,
    output logic [slcl_pkg::TOTAL_W-1:0]         evict_total,
    input  slcl_pkg::dp_cmd_t                    cmd,
    output slcl_pkg::dp_status_t                 status
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = MAX_SET_BITS;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W    = RANK_W;
    localparam int ENTRY_W  = 1 + ADDR_WIDTH + RANK_W;
    localparam int ROW_W    = MAX_WAYS * ENTRY_W;
    localparam int WCNT_W   = ($clog2(MAX_WAYS + 1) > slcl_pkg::WAYS_W) ?
                              $clog2(MAX_WAYS + 1) : slcl_pkg::WAYS_W;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    logic [slcl_pkg::SET_BITS_W-1:0]   set_bits_reg;
    logic [slcl_pkg::BLOCK_BITS_W-1:0] block_bits_reg;
    logic [slcl_pkg::WAYS_W-1:0]       ways_reg;
    logic [SET_W-1:0]                  clr_cnt_reg;
    logic [slcl_pkg::TOTAL_W-1:0]      hits_reg;
    logic [slcl_pkg::TOTAL_W-1:0]      misses_reg;
    logic [slcl_pkg::TOTAL_W-1:0]      evicts_reg;
    logic                              out_valid_reg;
    logic [slcl_pkg::OUTCOME_W-1:0]    outcome_reg;
    logic [ADDR_WIDTH-1:0]             tag_reg;
    logic [SET_W-1:0]                  set_reg;

    logic [ADDR_WIDTH-1:0] addr_m;
    logic [4:0]            s_eff;
    logic [5:0]            sb;
    logic [ADDR_WIDTH-1:0] tag_in;
    logic [ADDR_WIDTH-1:0] set_shift;
    logic [SET_W-1:0]      set_mask;
    logic [SET_W-1:0]      set_in;

    logic [ROW_W-1:0]      rd_row;
    logic [ROW_W-1:0]      row_new;
    logic                  wr_en;
    logic [SET_W-1:0]      wr_addr;
    logic [ROW_W-1:0]      wr_data;

    logic [WCNT_W-1:0]     ways_ext;
    logic [WCNT_W-1:0]     ways_eff;
    logic [MAX_WAYS-1:0]   line_v;
    logic [ADDR_WIDTH-1:0] line_tag [MAX_WAYS];
    logic [RANK_W-1:0]     line_rank [MAX_WAYS];
    logic [MAX_WAYS-1:0]   in_use;
    logic [MAX_WAYS-1:0]   match;
    logic [MAX_WAYS-1:0]   empty_c;
    logic [MAX_WAYS-1:0]   vic_c;
    logic [WAY_W-1:0]      hit_idx;
    logic [WAY_W-1:0]      empty_idx;
    logic [WAY_W-1:0]      vic_idx;
    logic [WAY_W-1:0]      touch_idx;
    logic [RANK_W-1:0]     old_rank;
    logic                  age_all;
    logic                  hit;
    logic                  any_empty;
    logic [slcl_pkg::OUTCOME_W-1:0] outcome_c;

    // Address split.
    assign addr_m    = address[ADDR_WIDTH-1:0];
    assign s_eff     = (5'(set_bits_reg) > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                            : 5'(set_bits_reg);
    assign sb        = 6'(s_eff) + 6'(block_bits_reg);
    assign tag_in    = addr_m >> sb;
    assign set_shift = addr_m >> block_bits_reg;

    always_comb
    begin
        for (int i = 0; i < SET_W; i++)
        begin
            set_mask[i] = (5'(i) < s_eff);
        end
    end

    assign set_in = set_shift[SET_W-1:0] & set_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= slcl_pkg::SET_BITS_RESET;
            block_bits_reg <= slcl_pkg::BLOCK_BITS_RESET;
            ways_reg       <= slcl_pkg::WAYS_RESET;
            clr_cnt_reg    <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            evicts_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    slcl_pkg::CFG_SET_BITS:   set_bits_reg   <= cfg_data[slcl_pkg::SET_BITS_W-1:0];
                    slcl_pkg::CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                    slcl_pkg::CFG_WAYS:       ways_reg       <= cfg_data[slcl_pkg::WAYS_W-1:0];
                    default:                  ;
                endcase
            end
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.update)
            begin
                if (hit)
                begin
                    if (hits_reg != slcl_pkg::TOTAL_MAX)
                    begin
                        hits_reg <= hits_reg + 1'b1;
                    end
                end
                else
                begin
                    if (misses_reg != slcl_pkg::TOTAL_MAX)
                    begin
                        misses_reg <= misses_reg + 1'b1;
                    end
                    if (!any_empty && evicts_reg != slcl_pkg::TOTAL_MAX)
                    begin
                        evicts_reg <= evicts_reg + 1'b1;
                    end
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tag_reg <= tag_in;
            set_reg <= set_in;
        end
        if (cmd.update)
        begin
            outcome_reg <= outcome_c;
        end
    end

    assign wr_en   = cmd.clear_step | cmd.update;
    assign wr_addr = cmd.clear_step ? clr_cnt_reg : set_reg;
    assign wr_data = cmd.clear_step ? '0 : row_new;

    slcl_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (set_in),
        .rd_data (rd_row)
    );

    // Way compare and victim selection on the row read for the current beat.
    assign ways_ext = WCNT_W'(ways_reg);
    assign ways_eff = (ways_reg == '0) ? WCNT_W'(1) :
                      ((ways_ext > WCNT_W'(MAX_WAYS)) ? WCNT_W'(MAX_WAYS) : ways_ext);

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            line_v[w]    = rd_row[w*ENTRY_W + ENTRY_W - 1];
            line_tag[w]  = rd_row[w*ENTRY_W + RANK_W +: ADDR_WIDTH];
            line_rank[w] = rd_row[w*ENTRY_W +: RANK_W];
            in_use[w]    = (WCNT_W'(w) < ways_eff);
            match[w]     = in_use[w] && line_v[w] && (line_tag[w] == tag_reg);
            empty_c[w]   = in_use[w] && !line_v[w];
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            vic_c[w] = in_use[w];
            for (int v = 0; v < MAX_WAYS; v++)
            begin
                if (in_use[v] && v < w && !(line_rank[v] < line_rank[w]))
                begin
                    vic_c[w] = 1'b0;
                end
                if (in_use[v] && v > w && !(line_rank[v] <= line_rank[w]))
                begin
                    vic_c[w] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        vic_idx   = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_idx = WAY_W'(w);
            end
            if (empty_c[w])
            begin
                empty_idx = WAY_W'(w);
            end
            if (vic_c[w])
            begin
                vic_idx = WAY_W'(w);
            end
        end
    end

    assign hit       = |match;
    assign any_empty = |empty_c;

    always_comb
    begin
        if (hit)
        begin
            touch_idx = hit_idx;
            old_rank  = line_rank[hit_idx];
            age_all   = 1'b0;
            outcome_c = slcl_pkg::OUTCOME_HIT;
        end
        else if (any_empty)
        begin
            touch_idx = empty_idx;
            old_rank  = '0;
            age_all   = 1'b1;
            outcome_c = slcl_pkg::OUTCOME_FILL;
        end
        else
        begin
            touch_idx = vic_idx;
            old_rank  = line_rank[vic_idx];
            age_all   = 1'b0;
            outcome_c = slcl_pkg::OUTCOME_EVICT;
        end
    end

    always_comb
    begin
        row_new = rd_row;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (WAY_W'(w) == touch_idx)
            begin
                row_new[w*ENTRY_W +: ENTRY_W] = {1'b1, tag_reg, {RANK_W{1'b0}}};
            end
            else if (in_use[w] && line_v[w] && (age_all || line_rank[w] < old_rank)
                     && line_rank[w] != RANK_MAX)
            begin
                row_new[w*ENTRY_W +: RANK_W] = line_rank[w] + 1'b1;
            end
        end
    end

    assign status.clear_last = (clr_cnt_reg == {SET_W{1'b1}});
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign outcome     = outcome_reg;
    assign hit_total   = hits_reg;
    assign miss_total  = misses_reg;
    assign evict_total = evicts_reg;

endmodule

// ----- sv/set_assoc_lru_cache_lookup_core.sv -----
// Top level of the set-associative LRU cache lookup block.
// Depends on slcl_pkg, slcl_ctrl and slcl_dp.
//
// Each access beat is split into block offset, set index and tag with the configured
// bit counts, looked up among the in-use ways of its set, and answered with one result
// beat carrying the outcome and saturating hit, miss and eviction totals. In the accept
// cycle the set row is read into the registered read port of the row memory; in the
// update state that follows, all ways are compared, the LRU ranks are updated and the row
// is written back, and only then is a new access accepted. The result sits in an output
// register; the update waits while a previous result is not yet taken. After reset a
// clearing pass writes all 2**MAX_SET_BITS set rows (256 at the default), during which
// no access is accepted. Configuration writes are accepted in every cycle.
module set_assoc_lru_cache_lookup_core #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [slcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [slcl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [63:0]                      address,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [slcl_pkg::OUTCOME_W-1:0]   outcome,
    output logic [slcl_pkg::TOTAL_W-1:0]     hit_total,
    output logic [slcl_pkg::TOTAL_W-1:0]     miss_total,
    output logic [slcl_pkg::TOTAL_W-1:0]     evict_total
);

    slcl_pkg::dp_cmd_t    cmd;
    slcl_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    slcl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    slcl_dp #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .address     (address),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .outcome     (outcome),
        .hit_total   (hit_total),
        .miss_total  (miss_total),
        .evict_total (evict_total),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ----- sv/slcl_checker.sv -----
// Port-level assertions for the cache lookup block and the bind that attaches them.
// Depends on slcl_pkg and set_assoc_lru_cache_lookup_core.
module slcl_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [slcl_pkg::OUTCOME_W-1:0]   outcome,
    input logic [slcl_pkg::TOTAL_W-1:0]     miss_total,
    input logic [slcl_pkg::TOTAL_W-1:0]     evict_total
);

    // A result beat stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before it was taken");

    // Every eviction is also counted as a miss.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> evict_total <= miss_total)
        else $error("eviction total exceeds miss total");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outcome == slcl_pkg::OUTCOME_HIT
                       || outcome == slcl_pkg::OUTCOME_FILL
                       || outcome == slcl_pkg::OUTCOME_EVICT))
        else $error("undefined outcome code");

    // One access is in flight at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("access accepted while the previous one is in work");

endmodule

bind set_assoc_lru_cache_lookup_core slcl_checker u_slcl_checker (.*);
